### hw/rtl/s2c_pkg.sv
// ----------------------------------------------------------------------------
// s2c_pkg - shared types and constants for the spherical to cartesian point
// CORDIC vector format, angle reduction and per-stage rotation step
// ----------------------------------------------------------------------------
package s2c_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int RANGE_BITS_DEF    = 16;
	localparam int ATAN_ENTRIES      = 24;
	localparam int ANGLE_W           = 16;
	localparam int META_W            = 16;
	localparam int VEC_W             = 32;
	localparam int FRAC_Q30          = 30;

	typedef logic signed [VEC_W-1:0] vec_t;
	typedef logic signed [VEC_W-1:0] ang_t;

	// x, y in Q2.30, z in Q3.28, flip set when the angle was moved by pi
	typedef struct packed {
		vec_t x;
		vec_t y;
		ang_t z;
		logic flip;
	} rot_t;

	localparam vec_t GAIN_Q30    = 32'sd652032874;
	localparam ang_t PI_Q28      = 32'sd843314857;
	localparam ang_t HALF_PI_Q28 = 32'sd421657428;
	localparam vec_t HALF_Q30    = 32'sd536870912;

	function automatic ang_t atan_q28(input logic [4:0] idx);
		ang_t a;
		case (idx)
			5'd0: a = 32'sd210828714;
			5'd1: a = 32'sd124459457;
			5'd2: a = 32'sd65760959;
			5'd3: a = 32'sd33381290;
			5'd4: a = 32'sd16755422;
			5'd5: a = 32'sd8385879;
			5'd6: a = 32'sd4193963;
			5'd7: a = 32'sd2097109;
			5'd8: a = 32'sd1048571;
			5'd9: a = 32'sd524287;
			5'd10: a = 32'sd262144;
			5'd11: a = 32'sd131072;
			5'd12: a = 32'sd65536;
			5'd13: a = 32'sd32768;
			5'd14: a = 32'sd16384;
			5'd15: a = 32'sd8192;
			5'd16: a = 32'sd4096;
			5'd17: a = 32'sd2048;
			5'd18: a = 32'sd1024;
			5'd19: a = 32'sd512;
			5'd20: a = 32'sd256;
			5'd21: a = 32'sd128;
			5'd22: a = 32'sd64;
			5'd23: a = 32'sd32;
			default: a = '0;
		endcase
		return a;
	endfunction

	// widen a Q3.13 angle to Q3.28 and fold it into +-pi/2
	function automatic rot_t angle_prep(input logic signed [ANGLE_W-1:0] a);
		rot_t o;
		ang_t z;
		z = ang_t'(a) <<< 15;
		o.x = GAIN_Q30;
		o.y = '0;
		if (z > HALF_PI_Q28) begin
			o.z = z - PI_Q28;
			o.flip = 1'b1;
		end else if (z < -HALF_PI_Q28) begin
			o.z = z + PI_Q28;
			o.flip = 1'b1;
		end else begin
			o.z = z;
			o.flip = 1'b0;
		end
		return o;
	endfunction

	// one rotation-mode micro-rotation
	function automatic rot_t cordic_step(input rot_t r, input int unsigned stage);
		rot_t o;
		vec_t dx;
		vec_t dy;
		ang_t a;
		dx = r.y >>> stage;
		dy = r.x >>> stage;
		a = atan_q28(5'(stage));
		o = r;
		if (!r.z[VEC_W-1]) begin
			o.x = r.x - dx;
			o.y = r.y + dy;
			o.z = r.z - a;
		end else begin
			o.x = r.x + dx;
			o.y = r.y - dy;
			o.z = r.z + a;
		end
		return o;
	endfunction

endpackage

### hw/rtl/s2c_cordic_cell.sv
// ----------------------------------------------------------------------------
// s2c_cordic_cell - one CORDIC stage for elevation and azimuth
// rotates both vectors by one step and carries the side data along
// ----------------------------------------------------------------------------
module s2c_cordic_cell #(
	parameter int STAGE  = 0,
	parameter int SIDE_W = 48
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  s2c_pkg::rot_t       in_el,
	input  s2c_pkg::rot_t       in_az,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	input  logic                out_ready,
	output s2c_pkg::rot_t       out_el,
	output s2c_pkg::rot_t       out_az,
	output logic [SIDE_W-1:0]   out_side
);
	import s2c_pkg::*;

	logic              valid_q;
	rot_t              el_q;
	rot_t              az_q;
	logic [SIDE_W-1:0] side_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			el_q   <= cordic_step(in_el, STAGE);
			az_q   <= cordic_step(in_az, STAGE);
			side_q <= in_side;
		end
	end

	assign out_valid = valid_q;
	assign out_el    = el_q;
	assign out_az    = az_q;
	assign out_side  = side_q;

endmodule

### hw/rtl/s2c_scale.sv
// ----------------------------------------------------------------------------
// s2c_scale - range scaling back end
// multiplies range by the sines and cosines, rounds, negates and saturates
// ----------------------------------------------------------------------------
module s2c_scale #(
	parameter int RANGE_BITS = s2c_pkg::RANGE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [RANGE_BITS-1:0]        range_v,
	input  s2c_pkg::rot_t                el,
	input  s2c_pkg::rot_t                az,
	input  logic [s2c_pkg::META_W-1:0]   snr,
	input  logic [s2c_pkg::META_W-1:0]   noise,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [RANGE_BITS:0]   x_coord,
	output logic signed [RANGE_BITS:0]   y_coord,
	output logic signed [RANGE_BITS:0]   z_coord,
	output logic [s2c_pkg::META_W-1:0]   snr_out,
	output logic [s2c_pkg::META_W-1:0]   noise_out
);
	import s2c_pkg::*;

	localparam int R_W   = RANGE_BITS + 1;
	localparam int P1_W  = R_W + VEC_W;
	localparam int RC_W  = RANGE_BITS + 2;
	localparam int P3_W  = RC_W + VEC_W;
	localparam int SAT_W = RANGE_BITS + 4;
	localparam logic signed [SAT_W-1:0] LIM_POS =
		{{(SAT_W-RANGE_BITS){1'b0}}, {RANGE_BITS{1'b1}}};
	localparam logic signed [SAT_W-1:0] LIM_NEG = -LIM_POS;

	function automatic logic signed [RANGE_BITS:0] sat(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] t;
		t = v;
		if (v > LIM_POS) begin
			t = LIM_POS;
		end else if (v < LIM_NEG) begin
			t = LIM_NEG;
		end
		return t[RANGE_BITS:0];
	endfunction

	logic ready_s1, ready_s2, ready_s3, ready_s4;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic signed [P1_W-1:0]  pce_s1, pse_s1;
	logic                    flip_s1;
	vec_t                    ca_s1, sa_s1;
	logic [2*META_W-1:0]     meta_s1, meta_s2, meta_s3, meta_s4;

	logic signed [RC_W-1:0]  rc_s2, zr_s2, zr_s3;
	vec_t                    ca_s2, sa_s2;

	logic signed [P3_W-1:0]  px_s3, py_s3;

	logic signed [RANGE_BITS:0] x_s4, y_s4, z_s4;

	logic signed [R_W-1:0]   rs;
	logic signed [P1_W-1:0]  pce_n, pse_n, pce_r, pse_r;
	logic signed [P3_W-1:0]  px_r, py_r;
	logic signed [SAT_W-1:0] xw, yw, zw;

	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	assign rs = {1'b0, range_v};

	always_comb begin
		pce_n = flip_s1 ? -pce_s1 : pce_s1;
		pse_n = flip_s1 ? -pse_s1 : pse_s1;
		pce_r = pce_n + P1_W'(HALF_Q30);
		pse_r = pse_n + P1_W'(HALF_Q30);
		px_r  = px_s3 + P3_W'(HALF_Q30);
		py_r  = py_s3 + P3_W'(HALF_Q30);
		xw    = -px_r[FRAC_Q30 +: SAT_W];
		yw    = py_r[FRAC_Q30 +: SAT_W];
		zw    = -SAT_W'(zr_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// range times elevation cosine and sine, azimuth terms sign-corrected
	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			pce_s1  <= P1_W'(rs) * P1_W'(el.x);
			pse_s1  <= P1_W'(rs) * P1_W'(el.y);
			flip_s1 <= el.flip;
			ca_s1   <= az.flip ? -az.x : az.x;
			sa_s1   <= az.flip ? -az.y : az.y;
			meta_s1 <= {snr, noise};
		end
	end

	// sign-correct and round the elevation products
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			rc_s2   <= pce_r[FRAC_Q30 +: RC_W];
			zr_s2   <= pse_r[FRAC_Q30 +: RC_W];
			ca_s2   <= ca_s1;
			sa_s2   <= sa_s1;
			meta_s2 <= meta_s1;
		end
	end

	// horizontal range times azimuth sine and cosine
	always_ff @(posedge clk) begin
		if (valid_s2 && ready_s3) begin
			px_s3   <= P3_W'(rc_s2) * P3_W'(sa_s2);
			py_s3   <= P3_W'(rc_s2) * P3_W'(ca_s2);
			zr_s3   <= zr_s2;
			meta_s3 <= meta_s2;
		end
	end

	// round, flip for the inverted mount, saturate
	always_ff @(posedge clk) begin
		if (valid_s3 && ready_s4) begin
			x_s4    <= sat(xw);
			y_s4    <= sat(yw);
			z_s4    <= sat(zw);
			meta_s4 <= meta_s3;
		end
	end

	assign out_valid = valid_s4;
	assign x_coord   = x_s4;
	assign y_coord   = y_s4;
	assign z_coord   = z_s4;
	assign snr_out   = meta_s4[2*META_W-1:META_W];
	assign noise_out = meta_s4[META_W-1:0];

endmodule

### hw/rtl/spherical_to_cartesian_point.sv
// ----------------------------------------------------------------------------
// spherical_to_cartesian_point - radar point to cartesian coordinates
//
// Input channel (in_valid/in_ready) takes one point per item: range in
// 1/256 m, elevation and azimuth in Q3.13 radians, snr and noise. Output
// channel (out_valid/out_ready) gives x = -R cos(el) sin(az),
// y = R cos(el) cos(az), z = -R sin(el) for an upside-down sensor, each
// saturated to +-(2^RANGE_BITS - 1), with snr and noise copied through.
// Throughput is one item per cycle while the receiver is ready. The pipeline
// has one angle folding stage, one cell per CORDIC stage (sine and cosine of
// both angles) and four stages of multiply, round and saturate.
// Every stage has its own valid and local ready, so when the receiver stalls
// the empty stages keep filling and in_ready drops only once all are full.
// Reset empties the pipeline; no item is lost or repeated across a stall.
// ----------------------------------------------------------------------------
module spherical_to_cartesian_point #(
	parameter int CORDIC_STAGES = s2c_pkg::CORDIC_STAGES_DEF,
	parameter int RANGE_BITS    = s2c_pkg::RANGE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [RANGE_BITS-1:0]              range,
	input  logic signed [s2c_pkg::ANGLE_W-1:0] elevation,
	input  logic signed [s2c_pkg::ANGLE_W-1:0] azimuth,
	input  logic [s2c_pkg::META_W-1:0]         snr,
	input  logic [s2c_pkg::META_W-1:0]         noise,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [RANGE_BITS:0]         x_coord,
	output logic signed [RANGE_BITS:0]         y_coord,
	output logic signed [RANGE_BITS:0]         z_coord,
	output logic [s2c_pkg::META_W-1:0]         snr_out,
	output logic [s2c_pkg::META_W-1:0]         noise_out
);
	import s2c_pkg::*;

	localparam int SIDE_W = RANGE_BITS + 2 * META_W;

	logic              valid_s0;
	rot_t              el_s0;
	rot_t              az_s0;
	logic [SIDE_W-1:0] side_s0;

	logic [CORDIC_STAGES:0] valid_c;
	logic [CORDIC_STAGES:0] ready_c;
	rot_t                   el_c   [CORDIC_STAGES+1];
	rot_t                   az_c   [CORDIC_STAGES+1];
	logic [SIDE_W-1:0]      side_c [CORDIC_STAGES+1];

	logic [SIDE_W-1:0] side_end;

	assign in_ready = !valid_s0 || ready_c[0];

	// angle folding stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (in_ready) begin
			valid_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			el_s0   <= angle_prep(elevation);
			az_s0   <= angle_prep(azimuth);
			side_s0 <= {range, snr, noise};
		end
	end

	assign valid_c[0] = valid_s0;
	assign el_c[0]    = el_s0;
	assign az_c[0]    = az_s0;
	assign side_c[0]  = side_s0;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
		s2c_cordic_cell #(
			.STAGE  (i),
			.SIDE_W (SIDE_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_ready  (ready_c[i]),
			.in_el     (el_c[i]),
			.in_az     (az_c[i]),
			.in_side   (side_c[i]),
			.out_valid (valid_c[i+1]),
			.out_ready (ready_c[i+1]),
			.out_el    (el_c[i+1]),
			.out_az    (az_c[i+1]),
			.out_side  (side_c[i+1])
		);
	end

	assign side_end = side_c[CORDIC_STAGES];

	s2c_scale #(
		.RANGE_BITS (RANGE_BITS)
	) u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_c[CORDIC_STAGES]),
		.in_ready  (ready_c[CORDIC_STAGES]),
		.range_v   (side_end[SIDE_W-1 -: RANGE_BITS]),
		.el        (el_c[CORDIC_STAGES]),
		.az        (az_c[CORDIC_STAGES]),
		.snr       (side_end[2*META_W-1:META_W]),
		.noise     (side_end[META_W-1:0]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.z_coord   (z_coord),
		.snr_out   (snr_out),
		.noise_out (noise_out)
	);

endmodule

### tb/tb_spherical_to_cartesian_point.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spherical_to_cartesian_point - self-checking bench for the point converter
//
// Drives radar points through the valid/ready input with bursts and gaps and
// takes results through a receiver that stalls on its own pattern, with long
// hold-offs that fill the pipeline. A directed table covers range and angle
// extremes, the fold points at +-pi/2 and +-pi, angles beyond pi and
// saturation. Random points follow. Every result is checked field by field
// against a bit-exact fixed-point CORDIC model, or the table for typed rows.
// ----------------------------------------------------------------------------
module tb_spherical_to_cartesian_point;

	localparam int RB          = s2c_pkg::RANGE_BITS_DEF;
	localparam int STAGES      = s2c_pkg::CORDIC_STAGES_DEF;
	localparam int ATAN_COUNT  = 24;
	localparam int RANDOM_PTS  = 1200;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_WAIT  = STAGES + 5 + 16;
	localparam int HOLD_LEN    = 150;

	localparam longint GAIN    = longint'(s2c_pkg::GAIN_Q30);
	localparam longint PI      = longint'(s2c_pkg::PI_Q28);
	localparam longint HALF_PI = longint'(s2c_pkg::HALF_PI_Q28);
	localparam longint HALF    = longint'(s2c_pkg::HALF_Q30);
	localparam longint LIM     = (longint'(1) << RB) - 1;

	typedef logic signed [RB:0] coord_t;

	typedef struct packed {
		logic [RB-1:0]       rng;
		logic signed [15:0]  el;
		logic signed [15:0]  az;
		logic [15:0]         snr;
		logic [15:0]         noise;
	} point_t;

	typedef struct packed {
		coord_t       x;
		coord_t       y;
		coord_t       z;
		logic [15:0]  snr;
		logic [15:0]  noise;
	} result_t;

	typedef struct {
		logic [RB-1:0]       rng;
		logic signed [15:0]  el;
		logic signed [15:0]  az;
		logic [15:0]         snr;
		logic [15:0]         noise;
		bit                  typed;
		coord_t              x;
		coord_t              y;
		coord_t              z;
	} dir_row_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [RB-1:0]       range;
	logic signed [15:0]  elevation;
	logic signed [15:0]  azimuth;
	logic [15:0]         snr;
	logic [15:0]         noise;
	logic                out_valid;
	logic                out_ready;
	coord_t              x_coord;
	coord_t              y_coord;
	coord_t              z_coord;
	logic [15:0]         snr_out;
	logic [15:0]         noise_out;

	result_t pending_coords[$];
	int      bad_points = 0;
	int      points_taken = 0;
	int      burst_left = 0;
	int      quiet_cycles = 0;

	longint atan_steps [ATAN_COUNT] = '{
		210828714, 124459457, 65760959, 33381290,
		16755422, 8385879, 4193963, 2097109,
		1048571, 524287, 262144, 131072,
		65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512,
		256, 128, 64, 32
	};

	dir_row_t directed_rows [23] = '{
		'{16'h0000, 16'sh0000, 16'sh0000, 16'h0000, 16'h0000, 1'b1, 17'sd0, 17'sd0, 17'sd0},
		'{16'h0000, 16'sh7FFF, 16'sh8000, 16'hFFFF, 16'hFFFF, 1'b1, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sd0, 16'sd0, 16'h1234, 16'h4321, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sd12867, 16'sd0, 16'h0001, 16'h8000, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sd12868, 16'sd0, 16'h8000, 16'h0001, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, -16'sd12867, 16'sd0, 16'h00FF, 16'hFF00, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, -16'sd12868, 16'sd0, 16'hFF00, 16'h00FF, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sd0, 16'sd12867, 16'h0F0F, 16'hF0F0, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sd0, 16'sd12868, 16'hF0F0, 16'h0F0F, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sd0, -16'sd12867, 16'h3333, 16'hCCCC, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sd0, -16'sd12868, 16'hCCCC, 16'h3333, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sd25736, 16'sd25736, 16'h0000, 16'hFFFF, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, -16'sd25736, -16'sd25736, 16'hFFFF, 16'h0000, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sh7FFF, 16'sh7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sh8000, 16'sh8000, 16'h8000, 16'h8000, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'h0001, 16'sd0, 16'sd0, 16'h0001, 16'h0002, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'h0001, 16'sd12868, -16'sd12868, 16'h0003, 16'h0004, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hAAAA, 16'sh5555, 16'shAAAA, 16'h5555, 16'hAAAA, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'h5555, 16'shAAAA, 16'sh5555, 16'hAAAA, 16'h5555, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'h8000, 16'sd6434, -16'sd6434, 16'h0100, 16'h0080, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sd25736, 16'sd0, 16'h0042, 16'h0024, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'hFFFF, 16'sd0, 16'sd25736, 16'h0024, 16'h0042, 1'b0, 17'sd0, 17'sd0, 17'sd0},
		'{16'h7FFF, -16'sd25736, 16'sd12868, 16'hBEEF, 16'hCAFE, 1'b0, 17'sd0, 17'sd0, 17'sd0}
	};

	spherical_to_cartesian_point i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.range     (range),
		.elevation (elevation),
		.azimuth   (azimuth),
		.snr       (snr),
		.noise     (noise),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.z_coord   (z_coord),
		.snr_out   (snr_out),
		.noise_out (noise_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void cordic_sin_cos(input logic signed [15:0] ang,
			output longint cosv, output longint sinv);
		longint zr;
		longint xr;
		longint yr;
		longint dx;
		longint dy;
		bit     folded;
		int     i;
		zr = longint'(ang) * 32768;
		xr = GAIN;
		yr = 0;
		folded = 1'b0;
		if (zr > HALF_PI) begin
			zr -= PI;
			folded = 1'b1;
		end else if (zr < -HALF_PI) begin
			zr += PI;
			folded = 1'b1;
		end
		for (i = 0; i < STAGES && i < ATAN_COUNT; i++) begin
			dx = yr >>> i;
			dy = xr >>> i;
			if (zr >= 0) begin
				xr -= dx;
				yr += dy;
				zr -= atan_steps[i];
			end else begin
				xr += dx;
				yr -= dy;
				zr += atan_steps[i];
			end
		end
		cosv = folded ? -xr : xr;
		sinv = folded ? -yr : yr;
	endfunction

	function automatic longint round_q30(input longint p);
		return (p + HALF) >>> 30;
	endfunction

	function automatic coord_t clamp_coord(input longint v);
		if (v > LIM)
			v = LIM;
		if (v < -LIM)
			v = -LIM;
		return coord_t'(v);
	endfunction

	function automatic result_t predict_point(input point_t p);
		longint  r;
		longint  ce;
		longint  se;
		longint  ca;
		longint  sa;
		longint  rc;
		result_t e;
		r = longint'(p.rng);
		cordic_sin_cos(p.el, ce, se);
		cordic_sin_cos(p.az, ca, sa);
		rc = round_q30(r * ce);
		e.x = clamp_coord(-round_q30(rc * sa));
		e.y = clamp_coord(round_q30(rc * ca));
		e.z = clamp_coord(-round_q30(r * se));
		e.snr = p.snr;
		e.noise = p.noise;
		return e;
	endfunction

	function automatic logic signed [15:0] pick_angle();
		int sgn;
		sgn = ($urandom_range(0, 1) == 1) ? -1 : 1;
		case ($urandom_range(0, 9))
			0, 1: return 16'($urandom);
			2: return 16'(sgn * (12868 + int'($urandom_range(0, 4)) - 2));
			3: return 16'(sgn * (25736 + int'($urandom_range(0, 6)) - 3));
			default: return 16'(int'($urandom_range(0, 51472)) - 25736);
		endcase
	endfunction

	function automatic logic [RB-1:0] pick_range();
		case ($urandom_range(0, 9))
			0, 1: return RB'(LIM - $urandom_range(0, 255));
			2: return RB'($urandom_range(0, 255));
			default: return RB'($urandom);
		endcase
	endfunction

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
			range <= RB'($urandom);
			elevation <= 16'($urandom);
			azimuth <= 16'($urandom);
			snr <= 16'($urandom);
			noise <= 16'($urandom);
		end
	endtask

	// bursts of random length with random gaps, some bursts long
	task automatic pace_sender();
		if (burst_left == 0) begin
			idle_cycles($urandom_range(0, 6));
			burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 200 : 24);
		end
		burst_left--;
	endtask

	task automatic send_point(input point_t p, input result_t e);
		@(negedge clk);
		in_valid <= 1'b1;
		range <= p.rng;
		elevation <= p.el;
		azimuth <= p.az;
		snr <= p.snr;
		noise <= p.noise;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		pending_coords.push_back(e);
		points_taken++;
	endtask

	initial begin : stimulus
		point_t  p;
		result_t e;
		int      n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		range = '0;
		elevation = '0;
		azimuth = '0;
		snr = '0;
		noise = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (n = 0; n < $size(directed_rows); n++) begin
			p.rng = directed_rows[n].rng;
			p.el = directed_rows[n].el;
			p.az = directed_rows[n].az;
			p.snr = directed_rows[n].snr;
			p.noise = directed_rows[n].noise;
			if (directed_rows[n].typed) begin
				e.x = directed_rows[n].x;
				e.y = directed_rows[n].y;
				e.z = directed_rows[n].z;
				e.snr = p.snr;
				e.noise = p.noise;
			end else begin
				e = predict_point(p);
			end
			pace_sender();
			send_point(p, e);
		end

		for (n = 0; n < RANDOM_PTS; n++) begin
			p.rng = pick_range();
			p.el = pick_angle();
			p.az = pick_angle();
			p.snr = 16'($urandom);
			p.noise = 16'($urandom);
			pace_sender();
			send_point(p, predict_point(p));
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_coords.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (bad_points == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : receiver
		rx_mode_t mode;
		int       run;
		int       k;
		int       holds;
		holds = 0;
		k = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			run = $urandom_range(8, 120);
			repeat (run) begin
				@(negedge clk);
				k++;
				case (mode)
					RX_OPEN: out_ready <= 1'b1;
					RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
					RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
					RX_PERIODIC: out_ready <= (k % 4 != 3);
				endcase
			end
			// long hold-off so the pipeline fills and in_ready drops
			if (holds < 2 && points_taken > 300 + 400 * holds) begin
				holds++;
				repeat (HOLD_LEN) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			bad_points++;
		end
	endtask

	always @(posedge clk) begin
		result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_coords.size() == 0) begin
				$display("%0t: unexpected item, actual x %0d y %0d z %0d", $time,
					x_coord, y_coord, z_coord);
				bad_points++;
			end else begin
				e = pending_coords.pop_front();
				check_field("x_coord", longint'(e.x), longint'(x_coord));
				check_field("y_coord", longint'(e.y), longint'(y_coord));
				check_field("z_coord", longint'(e.z), longint'(z_coord));
				check_field("snr_out", longint'(e.snr), longint'(snr_out));
				check_field("noise_out", longint'(e.noise), longint'(noise_out));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: timeout, no handshake for %0d cycles", $time, quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

endmodule
